/* hdl/ptt_pkg.sv */
// Package for the periodic timer table: slot record, operation and status codes,
// result buffer sizing and the state machine encoding.
// No dependencies.
package ptt_pkg;

   localparam int DEF_SLOTS = 16;
   localparam int MAX_RES   = 16;
   localparam int RES_IDX_W = $clog2(MAX_RES);
   localparam int RES_CNT_W = $clog2(MAX_RES + 1);

   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_ADD    = 2'd1;
   localparam logic [1:0] OP_CANCEL = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   localparam logic [2:0] ST_FIRED     = 3'd0;
   localparam logic [2:0] ST_NONE_DUE  = 3'd1;
   localparam logic [2:0] ST_ADDED     = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_CANCELLED = 3'd4;
   localparam logic [2:0] ST_NOT_FOUND = 3'd5;
   localparam logic [2:0] ST_CLEARED   = 3'd6;

   typedef struct packed {
      logic [31:0] deadline;
      logic [15:0] interval;
      logic [7:0]  remaining;
      logic        endless;
      logic [31:0] ident;
      logic [31:0] order;
   } rec_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] ident;
   } res_type;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_DECIDE = 4'b0100,
      S_OUT    = 4'b1000
   } state_type;

endpackage

/* hdl/ptt_slot_ram.sv */
// Slot record memory of the periodic timer table: one write port, one read port,
// registered read data. Depends on ptt_pkg.
module ptt_slot_ram #(
   parameter int SLOTS = ptt_pkg::DEF_SLOTS,
   parameter int IDX_W = $clog2(SLOTS)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  ptt_pkg::rec_type wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output ptt_pkg::rec_type rd_data
);
   import ptt_pkg::*;

   rec_type mem [SLOTS];
   rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/periodic_timer_table.sv */
// Periodic timer table top level: command stream in, result stream out.
// Depends on ptt_pkg and ptt_slot_ram.
//
//   channel | dir | handshake            | payload
//   req     | in  | req_tvalid/tready    | tuser: operation; tdata: add and cancel fields
//   rsp     | out | rsp_tvalid/tready    | tuser: status; tdata: id, wait, empty; tlast
//
// One command at a time. Every pass sweeps the slot memory, one read per cycle,
// then waits for the last read data, closes the sweep and takes a decide step.
// After the accept cycle a tick takes F + 2 passes for F firings, other commands
// two passes; then the result beats go out in order. Reset is synchronous and
// clears time, ids, order and all valid bits at once; no clearing pass. A
// stalled result beat holds.
module periodic_timer_table #(
   parameter int SLOTS = ptt_pkg::DEF_SLOTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] operation
   input  logic [79:0] req_tdata,   // [15:0] first_delay, [31:16] repeat_interval,
                                    // [39:32] repeat_count, [40] repeat_forever,
                                    // [72:41] target_id, [79:73] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,   // [2:0] status
   output logic [55:0] rsp_tdata,   // [31:0] timer_ident, [47:32] nearest_wait,
                                    // [48] table_empty, [55:49] zero
   output logic        rsp_tlast    // last_result
);
   import ptt_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   state_type             state_ff;
   logic [1:0]            op_ff;
   logic [15:0]           delay_ff, ival_ff;
   logic [7:0]            cnt_ff;
   logic                  forever_ff;
   logic [31:0]           target_ff;
   logic [31:0]           time_ff, next_ident_ff, next_order_ff;
   logic [SLOTS-1:0]      valid_ff, fired_ff;
   logic                  final_ff;

   // sweep control
   logic [CNT_W-1:0]      addr_ff;
   logic                  pend_ff;
   logic [IDX_W-1:0]      ridx_ff;

   // sweep findings
   logic                  best_found_ff;
   logic [IDX_W-1:0]      best_idx_ff;
   rec_type               best_rec_ff;
   logic [31:0]           best_kd_ff, best_ko_ff;
   logic                  free_found_ff;
   logic [IDX_W-1:0]      free_idx_ff;
   logic                  any_ff;
   logic                  match_found_ff;
   logic [IDX_W-1:0]      match_idx_ff;

   // result buffer
   logic [RES_CNT_W-1:0]  nres_ff;
   res_type               res_ff [MAX_RES];
   logic [RES_IDX_W-1:0]  out_idx_ff;
   logic [15:0]           wait_ff;
   logic                  empty_ff;

   // memory ports
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   rec_type               rd_rec;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   rec_type               wr_data;

   logic                  cand, better;
   logic [31:0]           key_d, key_o;
   logic                  due, fire_ok, add_ok, expire;
   logic [7:0]            rem_dec;
   rec_type               fire_rec, add_rec;
   logic [15:0]           add_delay, add_ival;
   logic [7:0]            add_cnt;
   logic                  out_last;

   ptt_slot_ram #(.SLOTS(SLOTS), .IDX_W(IDX_W)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_rec)
   );

   // Sweep: issue one read per cycle, compare the returning record.
   assign rd_en   = (state_ff == S_SCAN) && (addr_ff < CNT_W'(SLOTS));
   assign rd_addr = addr_ff[IDX_W-1:0];

   // Fired slots drop out only while looking for the next firing of a tick.
   assign cand  = pend_ff && valid_ff[ridx_ff] &&
                  !(!final_ff && (op_ff == OP_TICK) && fired_ff[ridx_ff]);
   assign key_d = rd_rec.deadline - time_ff;
   assign key_o = rd_rec.order - next_order_ff;
   assign better = !best_found_ff || ($signed(key_d) < $signed(best_kd_ff)) ||
                   ((key_d == best_kd_ff) && ($signed(key_o) < $signed(best_ko_ff)));

   // Firing: count down, reschedule unless spent.
   assign due     = (best_kd_ff == 32'd0) || best_kd_ff[31];
   assign rem_dec = best_rec_ff.remaining - 8'd1;
   assign expire  = !best_rec_ff.endless && (rem_dec == 8'd0);
   always_comb begin
      fire_rec           = best_rec_ff;
      fire_rec.deadline  = best_rec_ff.deadline + {16'd0, best_rec_ff.interval};
      fire_rec.order     = next_order_ff;
      fire_rec.remaining = best_rec_ff.endless ? best_rec_ff.remaining : rem_dec;
   end

   // New timer: zero delay, interval or count count as one.
   assign add_delay = (delay_ff == 16'd0) ? 16'd1 : delay_ff;
   assign add_ival  = (ival_ff == 16'd0) ? 16'd1 : ival_ff;
   assign add_cnt   = (cnt_ff == 8'd0) ? 8'd1 : cnt_ff;
   always_comb begin
      add_rec.deadline  = time_ff + {16'd0, add_delay};
      add_rec.interval  = add_ival;
      add_rec.remaining = add_cnt;
      add_rec.endless   = forever_ff;
      add_rec.ident     = next_ident_ff + 32'd1;
      add_rec.order     = next_order_ff;
   end

   assign fire_ok = (state_ff == S_DECIDE) && !final_ff && (op_ff == OP_TICK) &&
                    best_found_ff && due && (nres_ff < RES_CNT_W'(MAX_RES));
   assign add_ok  = (state_ff == S_DECIDE) && !final_ff && (op_ff == OP_ADD) &&
                    free_found_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = best_idx_ff;
      wr_data = fire_rec;
      if (fire_ok && !expire) begin
         wr_en = 1'b1;
      end else if (add_ok) begin
         wr_en   = 1'b1;
         wr_addr = free_idx_ff;
         wr_data = add_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         time_ff       <= '0;
         next_ident_ff <= '0;
         next_order_ff <= '0;
         valid_ff      <= '0;
         fired_ff      <= '0;
         final_ff      <= 1'b0;
         pend_ff       <= 1'b0;
         addr_ff       <= '0;
         nres_ff       <= '0;
         out_idx_ff    <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  op_ff      <= req_tuser;
                  delay_ff   <= req_tdata[15:0];
                  ival_ff    <= req_tdata[31:16];
                  cnt_ff     <= req_tdata[39:32];
                  forever_ff <= req_tdata[40];
                  target_ff  <= req_tdata[72:41];
                  if (req_tuser == OP_TICK) begin
                     time_ff <= time_ff + 32'd1;
                  end
                  fired_ff       <= '0;
                  nres_ff        <= '0;
                  final_ff       <= 1'b0;
                  addr_ff        <= '0;
                  pend_ff        <= 1'b0;
                  best_found_ff  <= 1'b0;
                  free_found_ff  <= 1'b0;
                  any_ff         <= 1'b0;
                  match_found_ff <= 1'b0;
                  state_ff       <= S_SCAN;
               end
            end
            S_SCAN: begin
               pend_ff <= rd_en;
               if (rd_en) begin
                  addr_ff <= addr_ff + CNT_W'(1);
                  ridx_ff <= addr_ff[IDX_W-1:0];
               end
               if (pend_ff) begin
                  if (valid_ff[ridx_ff]) begin
                     any_ff <= 1'b1;
                     if (!match_found_ff && (rd_rec.ident == target_ff)) begin
                        match_found_ff <= 1'b1;
                        match_idx_ff   <= ridx_ff;
                     end
                  end else if (!free_found_ff) begin
                     free_found_ff <= 1'b1;
                     free_idx_ff   <= ridx_ff;
                  end
                  if (cand && better) begin
                     best_found_ff <= 1'b1;
                     best_idx_ff   <= ridx_ff;
                     best_rec_ff   <= rd_rec;
                     best_kd_ff    <= key_d;
                     best_ko_ff    <= key_o;
                  end
               end
               if (!rd_en && !pend_ff) begin
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               // restart the sweep unless this was the closing one
               addr_ff        <= '0;
               pend_ff        <= 1'b0;
               best_found_ff  <= 1'b0;
               free_found_ff  <= 1'b0;
               any_ff         <= 1'b0;
               match_found_ff <= 1'b0;
               state_ff       <= S_SCAN;
               final_ff       <= 1'b1;
               if (final_ff) begin
                  empty_ff   <= !best_found_ff;
                  out_idx_ff <= '0;
                  state_ff   <= S_OUT;
                  if (!best_found_ff) begin
                     wait_ff <= 16'hFFFF;
                  end else if (best_kd_ff[31]) begin
                     wait_ff <= 16'd0;
                  end else if (|best_kd_ff[31:16]) begin
                     wait_ff <= 16'hFFFF;
                  end else begin
                     wait_ff <= best_kd_ff[15:0];
                  end
               end else begin
                  unique case (op_ff)
                     OP_TICK: begin
                        if (fire_ok) begin
                           res_ff[nres_ff[RES_IDX_W-1:0]] <= '{ST_FIRED,
                                                              best_rec_ff.ident};
                           nres_ff               <= nres_ff + RES_CNT_W'(1);
                           fired_ff[best_idx_ff] <= 1'b1;
                           final_ff              <= 1'b0;
                           if (expire) begin
                              valid_ff[best_idx_ff] <= 1'b0;
                           end else begin
                              next_order_ff <= next_order_ff + 32'd1;
                           end
                        end else if (nres_ff == '0) begin
                           res_ff[0] <= '{ST_NONE_DUE, 32'd0};
                           nres_ff   <= RES_CNT_W'(1);
                        end
                     end
                     OP_ADD: begin
                        nres_ff <= RES_CNT_W'(1);
                        if (add_ok) begin
                           valid_ff[free_idx_ff] <= 1'b1;
                           next_ident_ff         <= next_ident_ff + 32'd1;
                           next_order_ff         <= next_order_ff + 32'd1;
                           res_ff[0]             <= '{ST_ADDED, add_rec.ident};
                        end else begin
                           res_ff[0] <= '{ST_FULL, 32'd0};
                        end
                     end
                     OP_CANCEL: begin
                        nres_ff <= RES_CNT_W'(1);
                        if (!any_ff) begin
                           res_ff[0] <= '{ST_CANCELLED, 32'd0};
                        end else if (match_found_ff) begin
                           valid_ff[match_idx_ff] <= 1'b0;
                           res_ff[0]              <= '{ST_CANCELLED, 32'd0};
                        end else begin
                           res_ff[0] <= '{ST_NOT_FOUND, 32'd0};
                        end
                     end
                     default: begin
                        nres_ff   <= RES_CNT_W'(1);
                        valid_ff  <= '0;
                        res_ff[0] <= '{ST_CLEARED, 32'd0};
                     end
                  endcase
               end
            end
            S_OUT: begin
               if (rsp_tready) begin
                  if (out_last) begin
                     state_ff <= S_IDLE;
                  end else begin
                     out_idx_ff <= out_idx_ff + RES_IDX_W'(1);
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign out_last   = ({1'b0, out_idx_ff} + RES_CNT_W'(1)) == nres_ff;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tuser  = res_ff[out_idx_ff].status;
   assign rsp_tdata  = {7'd0, empty_ff, wait_ff, res_ff[out_idx_ff].ident};
   assign rsp_tlast  = out_last;

   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_SCAN))
      else $error("accepted command did not start a sweep");
   a_res_bound: assert property (@(posedge clock) disable iff (reset)
      nres_ff <= RES_CNT_W'(MAX_RES))
      else $error("result buffer overrun");
   a_out_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |-> (nres_ff != '0))
      else $error("result phase with no results");
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("command taken while results pending");

endmodule

/* tb/periodic_timer_table_tb.sv */
// Self-checking testbench for periodic_timer_table: directed command table, then random traffic.
// Depends on ptt_pkg and the periodic_timer_table RTL.
// Expected result beats come from a behavioral timer-table model kept inside this module.
module periodic_timer_table_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ptt_pkg::*;

   localparam int NSLOT       = DEF_SLOTS;
   localparam int RAND_ITEMS  = 400;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_WAIT  = 200;
   localparam int HOLD_START  = 3000;   // receiver holds off from here ...
   localparam int HOLD_LEN    = 1500;   // ... for this many cycles
   localparam int QUIET_START = 8000;   // no idling on either side in this window
   localparam int QUIET_LEN   = 3000;

   // One command on the request channel; lit_* is a hand-typed expectation
   typedef struct {
      logic [1:0]  op;
      logic [15:0] delay;
      logic [15:0] ival;
      logic [7:0]  count;
      logic        forever_flag;
      logic [31:0] target;
      bit          lit;
      logic [2:0]  lit_status;
      logic [31:0] lit_ident;
   } timer_cmd_type;

   // One result beat as the block should deliver it
   typedef struct {
      logic [2:0]  status;
      logic [31:0] ident;
      logic        last;
      logic [15:0] wait_ticks;
      logic        empty;
   } timer_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = '0;   // [1:0] operation
   logic [79:0] req_tdata = '0;   // [15:0] first_delay, [31:16] repeat_interval,
                                  // [39:32] repeat_count, [40] repeat_forever,
                                  // [72:41] target_id, [79:73] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [2:0]  rsp_tuser;        // [2:0] status
   logic [55:0] rsp_tdata;        // [31:0] timer_ident, [47:32] nearest_wait,
                                  // [48] table_empty, [55:49] zero
   logic        rsp_tlast;

   int unsigned cycle_count = 0;
   int unsigned rx_cycle    = 0;
   int unsigned fail_count  = 0;
   timer_beat_type pending_beats[$];
   timer_cmd_type  directed_cmds[$];

   // Model state of the timer table
   logic [31:0] now_ticks;
   logic [31:0] issued_ids;
   logic [31:0] order_stamp;
   logic        t_valid    [NSLOT];
   logic [31:0] t_deadline [NSLOT];
   logic [15:0] t_interval [NSLOT];
   logic [7:0]  t_left     [NSLOT];
   logic        t_forever  [NSLOT];
   logic [31:0] t_ident    [NSLOT];
   logic [31:0] t_order    [NSLOT];
   logic        t_fired    [NSLOT];

   periodic_timer_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   // Count cycles and stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d beats outstanding", $time, pending_beats.size());
         $display("periodic_timer_table test failed");
         $finish;
      end
   end

   function automatic bit in_quiet();
      return cycle_count >= QUIET_START && cycle_count < QUIET_START + QUIET_LEN;
   endfunction

   // Deadline ordering: signed distance from now, ties broken by scheduling order
   function automatic bit runs_first(int a, int b);
      logic [31:0] da, db;
      da = (t_deadline[a] - now_ticks) ^ 32'h8000_0000;
      db = (t_deadline[b] - now_ticks) ^ 32'h8000_0000;
      if (da != db) return da < db;
      return ((t_order[a] - order_stamp) ^ 32'h8000_0000) <
             ((t_order[b] - order_stamp) ^ 32'h8000_0000);
   endfunction

   function automatic int soonest_timer(bit skip_fired);
      int best;
      best = -1;
      for (int s = 0; s < NSLOT; s++) begin
         if (!t_valid[s] || (skip_fired && t_fired[s])) continue;
         if (best < 0 || runs_first(s, best)) best = s;
      end
      return best;
   endfunction

   // Apply one command to the model and queue the beats it produces
   function automatic void apply_timer_cmd(timer_cmd_type c);
      timer_beat_type beats[$];
      timer_beat_type b;
      logic [31:0] gap;
      logic [15:0] wait_ticks;
      logic        empty;
      int s;
      b = '{status: ST_NONE_DUE, ident: '0, last: 1'b0, wait_ticks: '0, empty: 1'b0};
      case (c.op)
         OP_TICK: begin
            foreach (t_fired[i]) t_fired[i] = 1'b0;
            now_ticks += 1;
            while (beats.size() < MAX_RES) begin
               s = soonest_timer(1'b1);
               if (s < 0) break;
               gap = t_deadline[s] - now_ticks;
               if (gap != 0 && !gap[31]) break;
               t_fired[s] = 1'b1;
               b.status = ST_FIRED;
               b.ident  = t_ident[s];
               beats.push_back(b);
               if (!t_forever[s]) begin
                  t_left[s] -= 1;
                  if (t_left[s] == 0) begin
                     t_valid[s] = 1'b0;
                     continue;
                  end
               end
               t_deadline[s] += t_interval[s];
               t_order[s] = order_stamp;
               order_stamp += 1;
            end
            if (beats.size() == 0) begin
               b.status = ST_NONE_DUE;
               b.ident  = '0;
               beats.push_back(b);
            end
         end
         OP_ADD: begin
            s = -1;
            for (int i = NSLOT - 1; i >= 0; i--) if (!t_valid[i]) s = i;
            if (s < 0) begin
               b.status = ST_FULL;
               b.ident  = '0;
            end else begin
               issued_ids += 1;
               t_valid[s]    = 1'b1;
               t_deadline[s] = now_ticks + ((c.delay == 0) ? 16'd1 : c.delay);
               t_interval[s] = (c.ival == 0) ? 16'd1 : c.ival;
               t_left[s]     = (c.count == 0) ? 8'd1 : c.count;
               t_forever[s]  = c.forever_flag;
               t_ident[s]    = issued_ids;
               t_order[s]    = order_stamp;
               order_stamp  += 1;
               b.status = ST_ADDED;
               b.ident  = issued_ids;
            end
            beats.push_back(b);
         end
         OP_CANCEL: begin
            // an empty table reports success
            b.status = (soonest_timer(1'b0) < 0) ? ST_CANCELLED : ST_NOT_FOUND;
            for (int i = 0; i < NSLOT; i++) begin
               if (b.status == ST_NOT_FOUND && t_valid[i] && t_ident[i] == c.target) begin
                  t_valid[i] = 1'b0;
                  b.status = ST_CANCELLED;
               end
            end
            beats.push_back(b);
         end
         default: begin
            foreach (t_valid[i]) t_valid[i] = 1'b0;
            b.status = ST_CLEARED;
            beats.push_back(b);
         end
      endcase
      // nearest wait and empty flag are taken after the whole step
      s = soonest_timer(1'b0);
      wait_ticks = 16'hFFFF;
      empty = 1'b1;
      if (s >= 0) begin
         gap = t_deadline[s] - now_ticks;
         empty = 1'b0;
         wait_ticks = gap[31] ? 16'd0 : (gap > 32'hFFFF) ? 16'hFFFF : gap[15:0];
      end
      foreach (beats[k]) begin
         beats[k].last       = (k == beats.size() - 1);
         beats[k].wait_ticks = wait_ticks;
         beats[k].empty      = empty;
         pending_beats.push_back(beats[k]);
      end
   endfunction

   // Drive one command from a falling edge, hold it until accepted, then predict
   task automatic send_cmd(timer_cmd_type c);
      while (!in_quiet() && $urandom_range(99) < 29) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c.op;
      req_tdata  <= {7'd0, c.target, c.forever_flag, c.count, c.ival, c.delay};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_timer_cmd(c);
      // hand-typed rows always give one beat: replace the predicted code and id
      if (c.lit) begin
         pending_beats[$].status = c.lit_status;
         pending_beats[$].ident  = c.lit_ident;
      end
      @(negedge clock);
   endtask

   function automatic timer_cmd_type make_cmd(logic [1:0] op, logic [15:0] delay,
                                              logic [15:0] ival, logic [7:0] count,
                                              logic fvr, logic [31:0] target);
      timer_cmd_type c;
      c = '{op: op, delay: delay, ival: ival, count: count, forever_flag: fvr,
            target: target, lit: 1'b0, lit_status: '0, lit_ident: '0};
      return c;
   endfunction

   function automatic void add_row(timer_cmd_type c, bit lit = 1'b0,
                                   logic [2:0] st = '0, logic [31:0] id = '0);
      c.lit = lit;
      c.lit_status = st;
      c.lit_ident = id;
      directed_cmds.push_back(c);
   endfunction

   function automatic timer_cmd_type random_cmd();
      timer_cmd_type c;
      int pick;
      pick = $urandom_range(99);
      c = make_cmd(OP_TICK, 16'($urandom()), 16'($urandom()), 8'($urandom()),
                   1'($urandom()), $urandom());
      if (pick < 45) c.op = OP_TICK;
      else if (pick < 80) c.op = OP_ADD;
      else if (pick < 96) c.op = OP_CANCEL;
      else c.op = OP_CLEAR;
      // mostly short timers so that firings and reschedules actually happen
      if ($urandom_range(9) < 8) begin
         c.delay = 16'($urandom_range(0, 12));
         c.ival  = 16'($urandom_range(0, 8));
         c.count = 8'($urandom_range(0, 4));
      end
      // aim cancels at live ids most of the time
      if ($urandom_range(3) != 0) c.target = issued_ids - $urandom_range(0, 20);
      return c;
   endfunction

   // Receiver: random idling, one long hold-off and one quiet window
   always @(negedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (reset)
         rsp_tready <= 1'b0;
      else if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
         rsp_tready <= 1'b0;
      else if (in_quiet())
         rsp_tready <= 1'b1;
      else
         rsp_tready <= ($urandom_range(99) >= 29);
   end

   // Checker: compare each accepted beat with the oldest expectation
   always @(posedge clock) begin
      timer_beat_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_beats.size() == 0) begin
            $display("%0t: unexpected beat status %0d id %0d", $time, rsp_tuser,
                     rsp_tdata[31:0]);
            fail_count++;
         end else begin
            e = pending_beats.pop_front();
            if (rsp_tuser !== e.status || rsp_tdata[31:0] !== e.ident ||
                rsp_tlast !== e.last || rsp_tdata[47:32] !== e.wait_ticks ||
                rsp_tdata[48] !== e.empty) begin
               $display("%0t: mismatch expected status %0d id %0d last %0d wait %0d empty %0d",
                        $time, e.status, e.ident, e.last, e.wait_ticks, e.empty);
               $display("%0t:          actual status %0d id %0d last %0d wait %0d empty %0d",
                        $time, rsp_tuser, rsp_tdata[31:0], rsp_tlast, rsp_tdata[47:32],
                        rsp_tdata[48]);
               fail_count++;
            end
         end
      end
   end

   initial begin
      int drain;
      now_ticks   = '0;
      issued_ids  = '0;
      order_stamp = '0;
      foreach (t_valid[i]) t_valid[i] = 1'b0;

      // Directed part: empty-table cases, zero fields, extremes, a full table
      add_row(make_cmd(OP_TICK,   0, 0, 0, 0, 0), 1, ST_NONE_DUE, 0);
      add_row(make_cmd(OP_CANCEL, 0, 0, 0, 0, 32'hFFFF_FFFF), 1, ST_CANCELLED, 0);
      add_row(make_cmd(OP_ADD,    0, 0, 0, 0, 0), 1, ST_ADDED, 1);
      add_row(make_cmd(OP_TICK,   0, 0, 0, 0, 0));
      add_row(make_cmd(OP_ADD,    16'hFFFF, 16'hFFFF, 8'hFF, 1, 32'hFFFF_FFFF), 1, ST_ADDED, 2);
      add_row(make_cmd(OP_CANCEL, 0, 0, 0, 0, 0), 1, ST_NOT_FOUND, 0);
      add_row(make_cmd(OP_ADD,    2, 3, 2, 0, 0), 1, ST_ADDED, 3);
      add_row(make_cmd(OP_ADD,    1, 1, 0, 1, 0), 1, ST_ADDED, 4);
      add_row(make_cmd(OP_TICK,   0, 0, 0, 0, 0));
      add_row(make_cmd(OP_TICK,   0, 0, 0, 0, 0));
      add_row(make_cmd(OP_CANCEL, 0, 0, 0, 0, 2), 1, ST_CANCELLED, 0);
      add_row(make_cmd(OP_TICK,   0, 0, 0, 0, 0));
      add_row(make_cmd(OP_CLEAR,  0, 0, 0, 0, 0), 1, ST_CLEARED, 0);
      // fill every slot with timers all due on the next tick, then overflow
      for (int i = 0; i < NSLOT; i++)
         add_row(make_cmd(OP_ADD, 1, 1, 2, i[0], 0));
      add_row(make_cmd(OP_ADD, 1, 1, 1, 0, 0), 1, ST_FULL, 0);
      add_row(make_cmd(OP_TICK, 0, 0, 0, 0, 0));
      add_row(make_cmd(OP_TICK, 0, 0, 0, 0, 0));
      add_row(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0), 1, ST_CLEARED, 0);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_cmds[i]) send_cmd(directed_cmds[i]);
      repeat (RAND_ITEMS) send_cmd(random_cmd());
      req_tvalid <= 1'b0;

      // Drain: wait for outstanding beats, then let trailing activity settle
      while (pending_beats.size() != 0) @(posedge clock);
      drain = 0;
      while (drain < DRAIN_WAIT) begin
         @(posedge clock);
         drain++;
      end
      if (fail_count == 0)
         $display("periodic_timer_table test passed");
      else
         $display("periodic_timer_table test failed");
      $finish;
   end

endmodule

/* sim.f */
hdl/ptt_pkg.sv
hdl/ptt_slot_ram.sv
hdl/periodic_timer_table.sv
tb/periodic_timer_table_tb.sv
